FILE: design/request_frame_builder_crc16_assert.svh
// ---------------------------------------------------------------------------
// request_frame_builder_crc16_assert.svh
// Assertion macros shared by the frame builder RTL
// ---------------------------------------------------------------------------
`ifndef REQUEST_FRAME_BUILDER_CRC16_ASSERT_SVH
`define REQUEST_FRAME_BUILDER_CRC16_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent holds, consequent holds in the same cycle
`define RFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// antecedent holds, consequent holds in the next cycle
`define RFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`else

`define RFB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/rfb_pkg.sv
// ---------------------------------------------------------------------------
// rfb_pkg
// Types, constants and byte helpers for the request frame builder
// ---------------------------------------------------------------------------
`default_nettype none

package rfb_pkg;

    // function codes with a payload tail
    localparam logic [7:0]  FN_WRITE        = 8'h06;
    localparam logic [7:0]  FN_READ         = 8'h01;

    // fixed register count sent with a read
    localparam logic [15:0] READ_COUNT      = 16'h0002;

    // crc-16, reflected polynomial
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;

    // device address after reset
    localparam logic [7:0]  DEV_ADDR_RESET  = 8'hAA;

    // byte positions within a frame
    localparam int unsigned IDX_W           = 3;
    localparam logic [IDX_W-1:0] LEN_SHORT  = 3'd4;
    localparam logic [IDX_W-1:0] LEN_LONG   = 3'd6;

    // input item
    typedef struct packed {
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] write_value;
    } request_t;

    // output item
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } result_t;

    // request as held for framing, with the address byte captured
    typedef struct packed {
        logic [7:0] dev_addr;
        request_t   req;
    } frame_req_t;

    // serialiser status, seen by the checks at the top level
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } ser_status_t;

    // crc update over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // number of bytes ahead of the crc
    function automatic logic [IDX_W-1:0] data_len(input logic [7:0] fn);
        logic [IDX_W-1:0] len;
        if (fn inside {FN_WRITE, FN_READ})
            len = LEN_LONG;
        else
            len = LEN_SHORT;
        return len;
    endfunction

    // data byte at a given position of the frame
    function automatic logic [7:0] data_byte(input frame_req_t       f,
                                             input logic [IDX_W-1:0] idx);
        logic [15:0] tail;
        logic [7:0]  b;
        if (f.req.function_code == FN_WRITE)
            tail = f.req.write_value;
        else
            tail = READ_COUNT;
        case (idx)
            3'd0:    b = f.dev_addr;
            3'd1:    b = f.req.function_code;
            3'd2:    b = f.req.register_address[15:8];
            3'd3:    b = f.req.register_address[7:0];
            3'd4:    b = tail[15:8];
            3'd5:    b = tail[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: design/rfb_req_buffer.sv
// ---------------------------------------------------------------------------
// rfb_req_buffer
// Input register holding one request until the serialiser takes it
// ---------------------------------------------------------------------------
`default_nettype none

module rfb_req_buffer
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire rfb_pkg::request_t   req,
    input  wire logic [7:0]          dev_addr,
    output logic                     load_valid,
    output rfb_pkg::frame_req_t      load_req,
    input  wire logic                load_take
);

    logic                pend_valid_reg;
    logic                pend_valid_next;
    rfb_pkg::frame_req_t pend_reg;
    rfb_pkg::frame_req_t pend_next;
    logic                accept;

    // one slot: stall while it is occupied
    assign req_stall = pend_valid_reg;
    assign accept    = req_valid && !pend_valid_reg;

    // slot occupancy and contents
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
            pend_next.dev_addr = dev_addr;
            pend_next.req      = req;
        end
        else if (load_take)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= pend_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign load_valid = pend_valid_reg;
    assign load_req   = pend_reg;

endmodule

`default_nettype wire

FILE: design/rfb_serializer.sv
// ---------------------------------------------------------------------------
// rfb_serializer
// Sends one frame a byte per cycle while the frame channel is not stalled, folding each data byte into the crc
// ---------------------------------------------------------------------------
`default_nettype none

module rfb_serializer
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load_valid,
    input  wire rfb_pkg::frame_req_t   load_req,
    output logic                       load_take,
    output logic                       frame_valid,
    input  wire logic                  frame_stall,
    output rfb_pkg::result_t           frame,
    output rfb_pkg::ser_status_t       status
);

    logic                           busy_reg;
    logic                           busy_next;
    rfb_pkg::frame_req_t            cur_reg;
    rfb_pkg::frame_req_t            cur_next;
    logic [rfb_pkg::IDX_W-1:0]      idx_reg;
    logic [rfb_pkg::IDX_W-1:0]      idx_next;
    logic [15:0]                    crc_reg;
    logic [15:0]                    crc_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    rfb_pkg::result_t               out_reg;
    rfb_pkg::result_t               out_next;

    logic                           advance;
    logic                           push;
    logic [rfb_pkg::IDX_W-1:0]      len;
    logic                           in_data;
    logic                           is_crc_hi;
    logic                           is_last;
    logic [7:0]                     next_byte;

    // position decode within the current frame
    assign len       = rfb_pkg::data_len(cur_reg.req.function_code);
    assign in_data   = idx_reg < len;
    assign is_crc_hi = idx_reg == len;
    assign is_last   = idx_reg == rfb_pkg::IDX_W'(len + 3'd1);

    // byte for the current position
    always_comb
    begin
        if (in_data)
            next_byte = rfb_pkg::data_byte(cur_reg, idx_reg);
        else if (is_crc_hi)
            next_byte = crc_reg[15:8];
        else
            next_byte = crc_reg[7:0];
    end

    // output register free or being drained
    assign advance   = !out_valid_reg || !frame_stall;
    assign push      = busy_reg && advance;
    assign load_take = load_valid && (!busy_reg || (push && is_last));

    // frame sequencing and output register
    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (push)
        begin
            out_valid_next     = 1'b1;
            out_next.frame_byte = next_byte;
            out_next.last_byte  = is_last;
            idx_next           = idx_reg + 3'd1;
            if (in_data)
                crc_next = rfb_pkg::crc_byte(crc_reg, next_byte);
            if (is_last)
                busy_next = 1'b0;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end

        // next request starts when the last byte is pushed into the output register, or at once when idle
        if (load_take)
        begin
            busy_next = 1'b1;
            cur_next  = load_req;
            idx_next  = '0;
            crc_next  = rfb_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        crc_reg <= crc_next;
        out_reg <= out_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;
    assign status.busy = busy_reg;
    assign status.idx  = idx_reg;

endmodule

`default_nettype wire

FILE: design/request_frame_builder_crc16.sv
// Request frame builder with crc-16 trailer.
// Request channel: req_valid / req_stall carry one request item (function
// code, register address, write value). Frame channel: frame_valid /
// frame_stall carry one frame byte per item, last_byte set on the crc low
// byte. An item moves at an edge with valid high and stall low.
// cfg_write_en / cfg_write_data load the device address byte that opens
// every frame; it is captured when a request is accepted.
// A request moves from the input register to the serialiser's current
// request register; its bytes leave through the output register. Frames
// are 8 bytes for functions 1 and 6, 6 otherwise, sent one byte per cycle
// unless stalled. A request held in the input register follows with no gap.
// Reset clears both item registers and sets the device address to 0xAA.
// When the receiver stalls, the byte on the frame channel holds, the frame
// pauses and the request channel stalls once its input register is full.
// ---------------------------------------------------------------------------
// request_frame_builder_crc16
// Top level: device address register, input register and frame serialiser
// ---------------------------------------------------------------------------
`default_nettype none

`include "request_frame_builder_crc16_assert.svh"

module request_frame_builder_crc16
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [7:0]          cfg_write_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire rfb_pkg::request_t   req,
    output logic                     frame_valid,
    input  wire logic                frame_stall,
    output rfb_pkg::result_t         frame
);

    logic [7:0]            dev_addr_reg;
    logic [7:0]            dev_addr_next;
    logic                  load_valid;
    logic                  load_take;
    rfb_pkg::frame_req_t   load_req;
    rfb_pkg::ser_status_t  ser_status;

    // device address register
    assign dev_addr_next = cfg_write_en ? cfg_write_data : dev_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= rfb_pkg::DEV_ADDR_RESET;
        else
            dev_addr_reg <= dev_addr_next;
    end

    // input register
    rfb_req_buffer u_req_buffer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .dev_addr   (dev_addr_reg),
        .load_valid (load_valid),
        .load_req   (load_req),
        .load_take  (load_take)
    );

    // frame serialiser
    rfb_serializer u_serializer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load_req    (load_req),
        .load_take   (load_take),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .status      (ser_status)
    );

    // checks
    // frames are at least six bytes, so two final bytes never follow each other
    `RFB_ASSERT_NEXT(a_no_back_to_back_last, clk, rst_n, frame_valid && frame.last_byte && !frame_stall, !(frame_valid && frame.last_byte))
    // an accepted request always fills the input register
    `RFB_ASSERT_NEXT(a_accept_fills_buffer, clk, rst_n, req_valid && !req_stall, load_valid)
    // the serialiser only takes a request while it is idle or ending a frame
    `RFB_ASSERT_SAME(a_take_when_free, clk, rst_n, load_take && ser_status.busy, ser_status.idx >= rfb_pkg::LEN_SHORT + 3'd1)

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the request frame builder against a predictor of its framing and crc.
// Requests go in from a queue in bursts with random gaps. Frame bytes are
// compared one by one with the bytes the predictor expects. The receiver
// stalls on its own pattern, and once for a long stretch to fill the block.
// The device address is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;

    localparam int HOLD_CYCLES = 100;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_write_en = 1'b0;
    logic     [7:0] cfg_write_data = 8'h00;
    logic     req_valid = 1'b0;
    logic     req_stall;
    rfb_pkg::request_t req = '0;
    logic     frame_valid;
    logic     frame_stall = 1'b0;
    rfb_pkg::result_t  frame;

    // predictor state and bookkeeping
    logic [7:0] device_addr = rfb_pkg::DEV_ADDR_RESET;
    rfb_pkg::request_t   requests_waiting[$];
    rfb_pkg::result_t    frame_bytes_due[$];
    bit         req_taken = 1'b0;
    bit         no_gaps = 1'b0;
    bit         pressure_on = 1'b0;
    logic       hold_off = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_run = 0;
    int         cycle_count = 0;
    int         error_count = 0;
    int         n_write = 0;
    int         n_read = 0;
    int         n_other = 0;
    int         n_bytes = 0;
    int         n_addr_writes = 0;

    request_frame_builder_crc16 uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame          (frame)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one mismatch, one line, for the first 50 mismatches
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // crc-16 over one byte, bit at a time, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  d);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ d[k];
            c = c >> 1;
            if (fb)
                c = c ^ rfb_pkg::CRC_POLY_REFL;
        end
        return c;
    endfunction

    // expected frame bytes for one accepted request
    task automatic predict_frame(input rfb_pkg::request_t r);
        logic [7:0]        bytes_out [0:7];
        logic [15:0]       crc;
        rfb_pkg::result_t  item;
        int                n;
        bytes_out[0] = device_addr;
        bytes_out[1] = r.function_code;
        bytes_out[2] = r.register_address[15:8];
        bytes_out[3] = r.register_address[7:0];
        n = 4;
        if (r.function_code == rfb_pkg::FN_WRITE)
        begin
            bytes_out[4] = r.write_value[15:8];
            bytes_out[5] = r.write_value[7:0];
            n = 6;
            n_write++;
        end
        else if (r.function_code == rfb_pkg::FN_READ)
        begin
            bytes_out[4] = rfb_pkg::READ_COUNT[15:8];
            bytes_out[5] = rfb_pkg::READ_COUNT[7:0];
            n = 6;
            n_read++;
        end
        else
            n_other++;
        crc = rfb_pkg::CRC_INIT;
        for (int i = 0; i < n; i++)
            crc = crc_update(crc, bytes_out[i]);
        bytes_out[n]     = crc[15:8];
        bytes_out[n + 1] = crc[7:0];
        n = n + 2;
        for (int i = 0; i < n; i++)
        begin
            item.frame_byte = bytes_out[i];
            item.last_byte  = (i == n - 1);
            frame_bytes_due.push_back(item);
        end
    endtask

    function automatic rfb_pkg::request_t make_request(input logic [7:0]  fn,
                                                       input logic [15:0] addr,
                                                       input logic [15:0] val);
        rfb_pkg::request_t r;
        r.function_code    = fn;
        r.register_address = addr;
        r.write_value      = val;
        return r;
    endfunction

    // mostly writes and reads, some other codes, occasional extremes
    function automatic rfb_pkg::request_t random_request();
        rfb_pkg::request_t r;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.function_code = rfb_pkg::FN_WRITE;
        else if (pick < 7)
            r.function_code = rfb_pkg::FN_READ;
        else
            r.function_code = 8'($urandom_range(0, 255));
        r.register_address = 16'($urandom_range(0, 65535));
        r.write_value      = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 15) == 0)
            r.register_address = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 15) == 0)
            r.write_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return r;
    endfunction

    // request side: note accepted items and predict their frames
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            predict_frame(requests_waiting.pop_front());
            req_taken = 1'b1;
        end
    end

    // request driver: bursts with random gaps, holds a stalled item
    always @(negedge clk)
    begin
        logic              next_valid;
        rfb_pkg::request_t next_req;
        next_valid = 1'b0;
        next_req   = req;
        if (req_valid && !req_taken)
            next_valid = 1'b1;
        else if (gap_left > 0 && !no_gaps)
            gap_left--;
        else if (requests_waiting.size() > 0)
        begin
            next_valid = 1'b1;
            next_req   = requests_waiting[0];
            if (burst_left == 0)
                burst_left = $urandom_range(1, 12);
            burst_left--;
            if (burst_left == 0)
                gap_left = $urandom_range(0, 6);
        end
        req_taken = 1'b0;
        req_valid <= next_valid;
        req       <= next_req;
    end

    // receiver stall pattern: none, random, periodic or random runs, re-picked at random
    always @(negedge clk)
    begin
        logic s;
        s = 1'b0;
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            1: s = 1'($urandom_range(0, 1));
            2: s = (cycle_count % 3 == 0);
            3:
            begin
                if (stall_run > 0)
                begin
                    s = 1'b1;
                    stall_run--;
                end
                else if ($urandom_range(0, 7) == 0)
                    stall_run = $urandom_range(1, 6);
            end
            default: s = 1'b0;
        endcase
        cycle_count++;
        frame_stall <= s || hold_off;
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (pressure_on);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // frame side: compare each byte with the oldest expected one
    always @(posedge clk)
    begin
        rfb_pkg::result_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (frame_bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected frame byte %02h last %0b",
                                          frame.frame_byte, frame.last_byte));
            else
            begin
                want = frame_bytes_due.pop_front();
                n_bytes++;
                if (frame.frame_byte !== want.frame_byte)
                    report_mismatch($sformatf("frame_byte got %02h want %02h",
                                              frame.frame_byte, want.frame_byte));
                if (frame.last_byte !== want.last_byte)
                    report_mismatch($sformatf("last_byte got %0b want %0b",
                                              frame.last_byte, want.last_byte));
            end
        end
    end

    // block idle: nothing queued, nothing outstanding
    task automatic wait_idle();
        while (requests_waiting.size() != 0 || frame_bytes_due.size() != 0 || req_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_device_address(input logic [7:0] a);
        wait_idle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= a;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        device_addr = a;
        n_addr_writes++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            requests_waiting.push_back(random_request());
    endtask

    // stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every kind of function, ignored value on read
        requests_waiting.push_back(make_request(rfb_pkg::FN_WRITE, 16'h0000, 16'h0000));
        requests_waiting.push_back(make_request(rfb_pkg::FN_WRITE, 16'hFFFF, 16'hFFFF));
        requests_waiting.push_back(make_request(rfb_pkg::FN_WRITE, 16'h5555, 16'hAAAA));
        requests_waiting.push_back(make_request(rfb_pkg::FN_WRITE, 16'hAAAA, 16'h5555));
        requests_waiting.push_back(make_request(rfb_pkg::FN_READ, 16'h0000, 16'h0000));
        requests_waiting.push_back(make_request(rfb_pkg::FN_READ, 16'hFFFF, 16'hFFFF));
        requests_waiting.push_back(make_request(rfb_pkg::FN_READ, 16'h1234, 16'hBEEF));
        requests_waiting.push_back(make_request(8'h00, 16'h0000, 16'hFFFF));
        requests_waiting.push_back(make_request(8'hFF, 16'hFFFF, 16'h0000));
        requests_waiting.push_back(make_request(8'h02, 16'h0102, 16'h0304));
        requests_waiting.push_back(make_request(8'h03, 16'h8000, 16'h0001));
        requests_waiting.push_back(make_request(8'h05, 16'h0001, 16'h8000));
        requests_waiting.push_back(make_request(8'h07, 16'h00FF, 16'hFF00));
        requests_waiting.push_back(make_request(8'h10, 16'hFF00, 16'h00FF));
        requests_waiting.push_back(make_request(8'h81, 16'h7FFF, 16'h7FFF));
        requests_waiting.push_back(make_request(8'h86, 16'hC3A5, 16'h5AC3));
        requests_waiting.push_back(make_request(8'h55, 16'h5555, 16'h5555));
        requests_waiting.push_back(make_request(8'hAA, 16'hAAAA, 16'hAAAA));

        // extreme device addresses, then random ones
        set_device_address(8'h00);
        queue_random(30);
        set_device_address(8'hFF);
        queue_random(30);

        // receiver holds off while requests keep coming, block fills up
        set_device_address(8'($urandom_range(0, 255)));
        no_gaps = 1'b1;
        pressure_on = 1'b1;
        queue_random(30);
        wait_idle();
        no_gaps = 1'b0;

        set_device_address(8'($urandom_range(0, 255)));
        queue_random(60);

        wait_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d write, %0d read and %0d other requests, %0d frame bytes",
                 n_write, n_read, n_other, n_bytes);
        $display("device address rewritten %0d times, %0d mismatches",
                 n_addr_writes, error_count);
        if (error_count == 0)
            $display("** request_frame_builder_crc16: PASSED **");
        else
            $display("** request_frame_builder_crc16: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d frame bytes outstanding", frame_bytes_due.size());
        $display("** request_frame_builder_crc16: FAILED **");
        $finish;
    end

endmodule
